### hdl/tfe_pkg.sv
`timescale 1ns / 1ps

package tfe_pkg;

  // Item kinds on the request channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  localparam logic [7:0] HEADER_BYTE = 8'h88;

  localparam int MAX_PAYLOAD_DEFAULT = 28;

  // Command queue depth, power of two
  localparam int QUEUE_DEPTH = 4;

  // Byte positions within one command
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // One classified request, ready to be expanded into bytes.
  // Start: header, byte_a (func), byte_b (length), [checksum].
  // Data:  byte_a (payload), [checksum].
  typedef struct packed {
    logic       is_start;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       has_cs;
    logic [7:0] cs;
  } cmd_t;

endpackage

### hdl/tfe_front.sv
`timescale 1ns / 1ps

module tfe_front #(
  parameter int MAX_PAYLOAD = tfe_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          kind,
  input  logic [7:0]    func_code,
  input  logic [7:0]    frame_length,
  input  logic [7:0]    data_byte,
  output logic          push,
  output tfe_pkg::cmd_t cmd
);

  localparam int         BlW    = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic           frame_open, frame_open_next;
  logic [BlW-1:0] bytes_left, bytes_left_next;
  logic [7:0]     running_sum, running_sum_next;
  logic [7:0]     hdr_sum;
  logic [7:0]     data_sum;

  assign hdr_sum  = tfe_pkg::HEADER_BYTE + func_code + frame_length;
  assign data_sum = running_sum + data_byte;

  always_comb begin
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    push             = 1'b0;
    cmd.is_start     = (kind == tfe_pkg::KIND_START);
    cmd.byte_a       = (kind == tfe_pkg::KIND_START) ? func_code : data_byte;
    cmd.byte_b       = frame_length;
    cmd.has_cs       = 1'b0;
    cmd.cs           = hdr_sum;
    if (accept) begin
      if (kind == tfe_pkg::KIND_START) begin
        if (frame_length <= MaxLen) begin
          push = 1'b1;
          if (frame_length == 8'd0) begin
            // empty frame closes at once
            cmd.has_cs       = 1'b1;
            frame_open_next  = 1'b0;
            bytes_left_next  = '0;
            running_sum_next = 8'd0;
          end else begin
            frame_open_next  = 1'b1;
            bytes_left_next  = BlW'(frame_length);
            running_sum_next = hdr_sum;
          end
        end
      end else if (frame_open) begin
        push   = 1'b1;
        cmd.cs = data_sum;
        if (bytes_left <= BlW'(1)) begin
          cmd.has_cs       = 1'b1;
          frame_open_next  = 1'b0;
          bytes_left_next  = '0;
          running_sum_next = 8'd0;
        end else begin
          bytes_left_next  = bytes_left - BlW'(1);
          running_sum_next = data_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= '0;
      running_sum <= 8'd0;
    end else begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

### hdl/tfe_queue.sv
`timescale 1ns / 1ps

module tfe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tfe_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output tfe_pkg::cmd_t rd_cmd
);

  localparam int AW = $clog2(tfe_pkg::QUEUE_DEPTH);

  tfe_pkg::cmd_t entries [tfe_pkg::QUEUE_DEPTH];
  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;

  assign rd_valid = (wr_ptr != rd_ptr);
  assign full     = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rd_cmd   = entries[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr[AW-1:0]] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (pop && rd_valid) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

endmodule

### hdl/tfe_back.sv
`timescale 1ns / 1ps

module tfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tfe_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    tx_byte,
  output logic          frame_end,
  output logic          run_last
);

  logic [1:0] idx, idx_next;
  logic [1:0] last_idx;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  assign load    = q_valid && (!out_valid || out_ready);
  assign at_last = (idx == last_idx);
  assign pop     = load && at_last;

  always_comb begin
    if (q_cmd.is_start) begin
      last_idx = q_cmd.has_cs ? tfe_pkg::POS_FOURTH : tfe_pkg::POS_THIRD;
    end else begin
      last_idx = q_cmd.has_cs ? tfe_pkg::POS_SECOND : tfe_pkg::POS_FIRST;
    end
  end

  always_comb begin
    sel_byte = q_cmd.cs;
    if (q_cmd.is_start) begin
      case (idx)
        tfe_pkg::POS_FIRST:  sel_byte = tfe_pkg::HEADER_BYTE;
        tfe_pkg::POS_SECOND: sel_byte = q_cmd.byte_a;
        tfe_pkg::POS_THIRD:  sel_byte = q_cmd.byte_b;
        default:             sel_byte = q_cmd.cs;
      endcase
    end else if (idx == tfe_pkg::POS_FIRST) begin
      sel_byte = q_cmd.byte_a;
    end
  end

  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = at_last ? tfe_pkg::POS_FIRST : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= tfe_pkg::POS_FIRST;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte   <= sel_byte;
      frame_end <= q_cmd.has_cs && at_last;
      run_last  <= at_last;
    end
  end

  // checksum always closes the burst of its request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("checksum byte not marked last");

  // a partly sent command stays at the queue head
  assert property (@(posedge clk) disable iff (rst)
    idx != tfe_pkg::POS_FIRST |-> q_valid)
    else $error("queue head lost mid-command");

  // popping a command restarts the byte position
  assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == tfe_pkg::POS_FIRST)
    else $error("byte position not reset after pop");

endmodule

### hdl/telemetry_frame_encoder.sv
`timescale 1ns / 1ps

// Telemetry frame encoder. Start requests (kind 0) open a frame and send the
// header 0x88, the function code and the length; a length above MAX_PAYLOAD
// is dropped silently. Data requests (kind 1) send their byte while a frame is
// open and are dropped otherwise. The last payload byte, or an empty frame's
// header, is followed by the 8-bit wrapping sum of the frame's bytes with
// frame_end set; run_last marks the final byte of each request. Rate: the
// output register sends one byte per cycle while out_ready allows; a data
// request sends one byte (two when it closes the frame) and a start three
// (four for an empty frame). A request is taken every cycle while the 4-entry
// command queue between the classifier and the byte sequencer has room; the
// first byte of a request is held in a queue entry, then the output register.
// Backpressure on out_ready stalls only the sequencer until the queue fills.
module telemetry_frame_encoder #(
  parameter int MAX_PAYLOAD = tfe_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] func_code,
  input  logic [7:0] frame_length,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       frame_end,
  output logic       run_last
);

  logic          accept;
  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  tfe_pkg::cmd_t wr_cmd;
  tfe_pkg::cmd_t q_cmd;

  // requests that emit nothing still need a free slot; keeps ready simple
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: classify, track frame state and checksum
  tfe_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind         (kind),
    .func_code    (func_code),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .push         (push),
    .cmd          (wr_cmd)
  );

  tfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // back: expand each command into its bytes
  tfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

endmodule
